### design/sdtq_pkg.sv
// sdtq_pkg: widths, entry and control types, and chain commands shared
// by the timer queue cells and the top level. No dependencies.
`timescale 1ns / 1ps
package sdtq_pkg;

	localparam int CAPACITY = 16;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int TAG_W    = 8;
	localparam int DL_W     = 56;
	localparam int PER_W    = 40;

	// chain commands
	localparam logic [1:0] CMD_HOLD = 2'd0;
	localparam logic [1:0] CMD_INS  = 2'd1;
	localparam logic [1:0] CMD_POP  = 2'd2;
	localparam logic [1:0] CMD_MARK = 2'd3;

	typedef struct packed {
		logic [DL_W-1:0]   deadline;
		logic [TAG_W-1:0]  tag;
		logic [SLOT_W-1:0] slot;
		logic [PER_W-1:0]  period;
	} payload_t;

	typedef struct packed {
		logic     valid;
		logic     pend;
		payload_t pay;
	} entry_t;

	typedef struct packed {
		logic [1:0]      cmd;
		payload_t        new_pay;
		logic [DL_W-1:0] now;
	} cell_ctrl_t;

endpackage

### design/sdtq_cell.sv
// sdtq_cell: one place of the sorted timer chain. Holds one entry, compares
// it with the entry being inserted and shifts to or from its neighbours.
// Depends on sdtq_pkg.
`timescale 1ns / 1ps
module sdtq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sdtq_pkg::cell_ctrl_t ctrl,
	input  sdtq_pkg::entry_t   prev_ent,
	input  logic               prev_go,
	input  sdtq_pkg::entry_t   next_ent,
	output sdtq_pkg::entry_t   ent,
	output logic               go
);

	logic               valid_q;
	logic               pend_q;
	sdtq_pkg::payload_t pay_q;
	sdtq_pkg::entry_t   ent_d;
	logic               less;

	assign ent = '{valid: valid_q, pend: pend_q, pay: pay_q};

	// key order: deadline, then tag, then slot
	always_comb begin
		if (ctrl.new_pay.deadline != pay_q.deadline) begin
			less = ctrl.new_pay.deadline < pay_q.deadline;
		end else if (ctrl.new_pay.tag != pay_q.tag) begin
			less = ctrl.new_pay.tag < pay_q.tag;
		end else begin
			less = ctrl.new_pay.slot < pay_q.slot;
		end
	end

	// a fresh entry never goes ahead of one still waiting to fire
	assign go = !valid_q || (!pend_q && less);

	always_comb begin
		ent_d = ent;
		case (ctrl.cmd)
			sdtq_pkg::CMD_INS: begin
				if (go) begin
					if (prev_go) begin
						ent_d = prev_ent;
					end else begin
						ent_d.valid = 1'b1;
						ent_d.pend  = 1'b0;
						ent_d.pay   = ctrl.new_pay;
					end
				end
			end
			sdtq_pkg::CMD_POP: begin
				ent_d = next_ent;
			end
			sdtq_pkg::CMD_MARK: begin
				ent_d.pend = valid_q && (pay_q.deadline <= ctrl.now);
			end
			default: begin
				ent_d = ent;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
			pend_q  <= ent_d.pend;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= ent_d.pay;
	end

endmodule

### design/sorted_deadline_timer_queue.sv
// sorted_deadline_timer_queue: top level with the control sequencer, slot
// map and result register around a chain of sdtq_cell. Depends on sdtq_pkg
// and sdtq_cell.
`timescale 1ns / 1ps
// Timers sit in a chain of cells kept sorted by deadline, tag and slot, so
// the earliest deadline is always at the head. An add beat is inserted as
// it is taken, unless the table is full, and its result is loaded in ST_FIN.
// A check beat marks the expired timers, then pops them from the head one
// at a time, re-inserting each periodic timer at now + period (saturating)
// in ST_INS, and ends in ST_FIN with the final result. Each pop and insert
// step moves the whole chain at once. Pops wait while the result register
// is still held by a stall. A new beat is taken once the previous one has
// loaded its final result.
module sorted_deadline_timer_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [sdtq_pkg::TAG_W-1:0]    timer_tag,
	input  logic [sdtq_pkg::DL_W-1:0]     expire_at,
	input  logic [sdtq_pkg::PER_W-1:0]    period,
	input  logic [sdtq_pkg::DL_W-1:0]     now_time,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          fired_valid,
	output logic [sdtq_pkg::TAG_W-1:0]    fired_tag,
	output logic                          earliest_changed,
	output logic                          table_full,
	output logic                          next_valid,
	output logic [sdtq_pkg::DL_W-1:0]     next_deadline,
	output logic                          last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_INS  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]                      state_q;
	logic [sdtq_pkg::CAPACITY-1:0]   slot_used_q;
	logic [sdtq_pkg::DL_W-1:0]       now_q;
	sdtq_pkg::payload_t              hold_q;
	logic                            more_q;
	logic                            fin_fired_q;
	logic [sdtq_pkg::TAG_W-1:0]      fin_tag_q;
	logic                            fin_ec_q;
	logic                            fin_full_q;

	logic                            out_valid_q;
	logic                            fired_valid_q;
	logic [sdtq_pkg::TAG_W-1:0]      fired_tag_q;
	logic                            earliest_changed_q;
	logic                            table_full_q;
	logic                            next_valid_q;
	logic [sdtq_pkg::DL_W-1:0]       next_deadline_q;
	logic                            last_q;

	sdtq_pkg::cell_ctrl_t            ctrl;
	sdtq_pkg::entry_t                ent [sdtq_pkg::CAPACITY];
	logic                            go  [sdtq_pkg::CAPACITY];
	sdtq_pkg::entry_t                head;
	logic [sdtq_pkg::SLOT_W-1:0]     free_slot;
	logic                            full;
	logic                            out_free;
	logic                            out_load;
	logic                            in_take;
	logic                            last_pop;
	logic [sdtq_pkg::DL_W:0]         reload_sum;
	logic [sdtq_pkg::DL_W-1:0]       reload_dl;

	assign head     = ent[0];
	assign full     = &slot_used_q;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && (state_q == ST_IDLE);
	assign last_pop = !ent[1].pend;

	// a result beat is loaded by every pop but the last, and by the final step
	assign out_load = ((state_q == ST_POP) && head.pend && out_free && !last_pop)
		|| ((state_q == ST_FIN) && out_free);

	assign reload_sum = {1'b0, now_q} + {{(sdtq_pkg::DL_W + 1 - sdtq_pkg::PER_W){1'b0}},
		head.pay.period};
	assign reload_dl  = reload_sum[sdtq_pkg::DL_W] ? {sdtq_pkg::DL_W{1'b1}}
		: reload_sum[sdtq_pkg::DL_W-1:0];

	// lowest free slot
	always_comb begin
		free_slot = '0;
		for (int i = sdtq_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_slot = sdtq_pkg::SLOT_W'(i);
			end
		end
	end

	always_comb begin
		ctrl.cmd     = sdtq_pkg::CMD_HOLD;
		ctrl.now     = now_time;
		ctrl.new_pay = hold_q;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.new_pay.deadline = expire_at;
				ctrl.new_pay.tag      = timer_tag;
				ctrl.new_pay.slot     = free_slot;
				ctrl.new_pay.period   = period;
				if (in_take) begin
					if (kind) begin
						ctrl.cmd = sdtq_pkg::CMD_MARK;
					end else if (!full) begin
						ctrl.cmd = sdtq_pkg::CMD_INS;
					end
				end
			end
			ST_POP: begin
				if (head.pend && out_free) begin
					ctrl.cmd = sdtq_pkg::CMD_POP;
				end
			end
			ST_INS: begin
				ctrl.cmd = sdtq_pkg::CMD_INS;
			end
			ST_FIN: begin
				ctrl.cmd = sdtq_pkg::CMD_HOLD;
			end
			default: begin
				ctrl.cmd = sdtq_pkg::CMD_HOLD;
			end
		endcase
	end

	for (genvar i = 0; i < sdtq_pkg::CAPACITY; i++) begin : g_cell
		sdtq_pkg::entry_t prev_ent;
		sdtq_pkg::entry_t next_ent;
		logic             prev_go;

		if (i == 0) begin : g_head
			assign prev_ent = '0;
			assign prev_go  = 1'b0;
		end else begin : g_body
			assign prev_ent = ent[i-1];
			assign prev_go  = go[i-1];
		end

		if (i == sdtq_pkg::CAPACITY - 1) begin : g_tail
			assign next_ent = '0;
		end else begin : g_mid
			assign next_ent = ent[i+1];
		end

		sdtq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.prev_ent (prev_ent),
			.prev_go  (prev_go),
			.next_ent (next_ent),
			.ent      (ent[i]),
			.go       (go[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_used_q <= '0;
			more_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= kind ? ST_POP : ST_FIN;
						if (!kind && !full) begin
							slot_used_q[free_slot] <= 1'b1;
						end
					end
				end
				ST_POP: begin
					if (!head.pend) begin
						state_q <= ST_FIN;
					end else if (out_free) begin
						more_q <= !last_pop;
						if (head.pay.period != '0) begin
							state_q <= ST_INS;
						end else begin
							slot_used_q[head.pay.slot] <= 1'b0;
							if (last_pop) begin
								state_q <= ST_FIN;
							end
						end
					end
				end
				ST_INS: begin
					state_q <= more_q ? ST_POP : ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload side of the sequencer and result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					now_q       <= now_time;
					fin_fired_q <= 1'b0;
					fin_tag_q   <= '0;
					fin_full_q  <= !kind && full;
					fin_ec_q    <= !kind && !full
						&& (!head.valid || expire_at < head.pay.deadline);
				end
			end
			ST_POP: begin
				if (head.pend && out_free) begin
					hold_q <= '{deadline: reload_dl, tag: head.pay.tag,
						slot: head.pay.slot, period: head.pay.period};
					if (last_pop) begin
						fin_fired_q <= 1'b1;
						fin_tag_q   <= head.pay.tag;
					end else begin
						fired_valid_q      <= 1'b1;
						fired_tag_q        <= head.pay.tag;
						earliest_changed_q <= 1'b0;
						table_full_q       <= 1'b0;
						next_valid_q       <= 1'b0;
						next_deadline_q    <= '0;
						last_q             <= 1'b0;
					end
				end
			end
			ST_INS: begin
			end
			ST_FIN: begin
				if (out_free) begin
					fired_valid_q      <= fin_fired_q;
					fired_tag_q        <= fin_tag_q;
					earliest_changed_q <= fin_ec_q;
					table_full_q       <= fin_full_q;
					next_valid_q       <= head.valid;
					next_deadline_q    <= head.valid ? head.pay.deadline : '0;
					last_q             <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid        = out_valid_q;
	assign fired_valid      = fired_valid_q;
	assign fired_tag        = fired_tag_q;
	assign earliest_changed = earliest_changed_q;
	assign table_full       = table_full_q;
	assign next_valid       = next_valid_q;
	assign next_deadline    = next_deadline_q;
	assign last             = last_q;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench: directed and random add and check beats for sorted_deadline_timer_queue, with
// every result beat compared against a timer table kept in step with the block.
// Depends on sdtq_pkg and sorted_deadline_timer_queue.
module testbench;

	localparam int CAPACITY = sdtq_pkg::CAPACITY;
	localparam int TAG_W    = sdtq_pkg::TAG_W;
	localparam int DL_W     = sdtq_pkg::DL_W;
	localparam int PER_W    = sdtq_pkg::PER_W;

	localparam bit KIND_ADD   = 1'b0;
	localparam bit KIND_CHECK = 1'b1;
	localparam logic [DL_W-1:0]  DL_MAX  = '1;
	localparam logic [PER_W-1:0] PER_MAX = '1;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic [TAG_W-1:0]   timer_tag;
	logic [DL_W-1:0]    expire_at;
	logic [PER_W-1:0]   period;
	logic [DL_W-1:0]    now_time;
	logic               out_valid;
	logic               out_stall;
	logic               fired_valid;
	logic [TAG_W-1:0]   fired_tag;
	logic               earliest_changed;
	logic               table_full;
	logic               next_valid;
	logic [DL_W-1:0]    next_deadline;
	logic               last;

	bit steady;

	typedef struct packed {
		logic             fired_valid;
		logic [TAG_W-1:0] fired_tag;
		logic             earliest_changed;
		logic             table_full;
		logic             next_valid;
		logic [DL_W-1:0]  next_deadline;
		logic             last;
	} timer_result_t;

	class timer_book;
		logic [DL_W-1:0]  dl_mem  [CAPACITY];
		logic [PER_W-1:0] per_mem [CAPACITY];
		logic [TAG_W-1:0] tag_mem [CAPACITY];
		bit               live    [CAPACITY];
		timer_result_t    owed[$];
		int               mismatches;

		function new();
			foreach (live[i]) live[i] = 1'b0;
			mismatches = 0;
		endfunction

		function bit earliest(output logic [DL_W-1:0] dl);
			bit any;
			any = 1'b0;
			dl = '0;
			for (int i = 0; i < CAPACITY; i++) begin
				if (live[i] && (!any || dl_mem[i] < dl)) begin
					dl = dl_mem[i];
					any = 1'b1;
				end
			end
			return any;
		endfunction

		// deadline first, then tag, then entry number
		function bit key_before(int a, int b);
			if (dl_mem[a] != dl_mem[b])
				return dl_mem[a] < dl_mem[b];
			if (tag_mem[a] != tag_mem[b])
				return tag_mem[a] < tag_mem[b];
			return a < b;
		endfunction

		function int periodic_count();
			int n;
			n = 0;
			for (int i = 0; i < CAPACITY; i++)
				if (live[i] && per_mem[i] != '0)
					n++;
			return n;
		endfunction

		function void note_beat(logic k, logic [TAG_W-1:0] tag, logic [DL_W-1:0] exp,
				logic [PER_W-1:0] per, logic [DL_W-1:0] now);
			timer_result_t r;
			logic [DL_W-1:0] first;
			logic [DL_W-1:0] nd;
			logic [DL_W:0] sum;
			bit any;
			bit nv;
			bit due [CAPACITY];
			int fired[$];
			int slot;
			int pick;
			int e;
			r = '0;
			if (k == KIND_ADD) begin
				any = earliest(first);
				slot = -1;
				for (int i = CAPACITY - 1; i >= 0; i--)
					if (!live[i])
						slot = i;
				if (slot < 0) begin
					r.table_full = 1'b1;
				end else begin
					r.earliest_changed = !any || exp < first;
					dl_mem[slot] = exp;
					per_mem[slot] = per;
					tag_mem[slot] = tag;
					live[slot] = 1'b1;
				end
				nv = earliest(nd);
				r.next_valid = nv;
				r.next_deadline = nd;
				r.last = 1'b1;
				owed.push_back(r);
			end else begin
				foreach (due[i]) due[i] = live[i] && dl_mem[i] <= now;
				do begin
					pick = -1;
					for (int i = 0; i < CAPACITY; i++)
						if (due[i] && (pick < 0 || key_before(i, pick)))
							pick = i;
					if (pick >= 0) begin
						due[pick] = 1'b0;
						fired.push_back(pick);
					end
				end while (pick >= 0);
				// periodic timers come back at now + period, clamped at the top
				foreach (fired[j]) begin
					e = fired[j];
					if (per_mem[e] != '0) begin
						sum = {1'b0, now} + {{(DL_W + 1 - PER_W){1'b0}}, per_mem[e]};
						dl_mem[e] = sum[DL_W] ? DL_MAX : sum[DL_W-1:0];
					end else begin
						live[e] = 1'b0;
					end
				end
				nv = earliest(nd);
				if (fired.size() == 0) begin
					r.next_valid = nv;
					r.next_deadline = nd;
					r.last = 1'b1;
					owed.push_back(r);
				end
				foreach (fired[j]) begin
					r = '0;
					r.fired_valid = 1'b1;
					r.fired_tag = tag_mem[fired[j]];
					if (j == fired.size() - 1) begin
						r.next_valid = nv;
						r.next_deadline = nd;
						r.last = 1'b1;
					end
					owed.push_back(r);
				end
			end
		endfunction

		function void field_check(string name, logic [63:0] want, logic [63:0] seen);
			if (seen !== want) begin
				$display("%0t: %s expected %h got %h", $time, name, want, seen);
				mismatches++;
			end
		endfunction

		function void match_beat(timer_result_t got);
			timer_result_t want;
			if (owed.size() == 0) begin
				$display("%0t: result beat with none expected, got %h", $time, got);
				mismatches++;
				return;
			end
			want = owed.pop_front();
			field_check("fired_valid", 64'(want.fired_valid), 64'(got.fired_valid));
			field_check("fired_tag", 64'(want.fired_tag), 64'(got.fired_tag));
			field_check("earliest_changed", 64'(want.earliest_changed),
				64'(got.earliest_changed));
			field_check("table_full", 64'(want.table_full), 64'(got.table_full));
			field_check("next_valid", 64'(want.next_valid), 64'(got.next_valid));
			field_check("next_deadline", 64'(want.next_deadline), 64'(got.next_deadline));
			field_check("last", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	timer_book book = new();

	sorted_deadline_timer_queue dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.timer_tag        (timer_tag),
		.expire_at        (expire_at),
		.period           (period),
		.now_time         (now_time),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.fired_valid      (fired_valid),
		.fired_tag        (fired_tag),
		.earliest_changed (earliest_changed),
		.table_full       (table_full),
		.next_valid       (next_valid),
		.next_deadline    (next_deadline),
		.last             (last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int draw_gap();
		return steady ? 0 : int'($urandom_range(0, 3));
	endfunction

	task automatic send_beat(logic k, logic [TAG_W-1:0] tag, logic [DL_W-1:0] exp,
			logic [PER_W-1:0] per, logic [DL_W-1:0] now);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind <= k;
		timer_tag <= tag;
		expire_at <= exp;
		period <= per;
		now_time <= now;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		book.note_beat(k, tag, exp, per, now);
	endtask

	initial begin : result_sink
		timer_result_t seen;
		int hold;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_gap();
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			seen.fired_valid = fired_valid;
			seen.fired_tag = fired_tag;
			seen.earliest_changed = earliest_changed;
			seen.table_full = table_full;
			seen.next_valid = next_valid;
			seen.next_deadline = next_deadline;
			seen.last = last;
			book.match_beat(seen);
		end
	end

	initial begin : stimulus
		logic [DL_W-1:0]  sim_now;
		logic [DL_W-1:0]  exp;
		logic [DL_W-1:0]  now;
		logic [PER_W-1:0] per;
		logic [TAG_W-1:0] tag;
		int add_bias;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_ADD;
		timer_tag = '0;
		expire_at = '0;
		period = '0;
		now_time = '0;
		steady = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_beat(KIND_CHECK, 8'h00, '0, '0, '0);          // empty table, nothing due
		send_beat(KIND_ADD, 8'h00, '0, '0, '0);            // first timer is always earliest
		send_beat(KIND_ADD, 8'hff, DL_MAX, PER_MAX, '0);
		send_beat(KIND_ADD, 8'h05, 56'd100, '0, DL_MAX);
		send_beat(KIND_ADD, 8'h03, 56'd100, 40'd7, '0);
		send_beat(KIND_ADD, 8'h05, 56'd100, '0, '0);       // same tag twice
		send_beat(KIND_CHECK, '0, '0, '0, 56'd100);
		send_beat(KIND_CHECK, 8'hff, DL_MAX, PER_MAX, DL_MAX);  // reloads clamp at the top
		send_beat(KIND_CHECK, '0, '0, '0, DL_MAX);         // equal deadlines, tag decides
		// pairs share a deadline with falling tags
		for (int i = 0; i < 14; i++)
			send_beat(KIND_ADD, 8'(40 - i), 56'(1000 + (i / 2) * 5), '0, '0);
		send_beat(KIND_ADD, 8'h77, 56'd10, 40'd3, '0);     // no free entry
		send_beat(KIND_CHECK, '0, '0, '0, 56'd2000);

		sim_now = 56'd5000;
		add_bias = 55;
		for (int i = 0; i < 245; i++) begin
			if (i % 40 == 0) begin
				steady = ($urandom_range(0, 2) == 0);
				add_bias = int'($urandom_range(40, 75));
			end
			if ($urandom_range(0, 99) < add_bias) begin
				tag = TAG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
					: $urandom_range(0, 255));
				case ($urandom_range(0, 9))
					0: exp = DL_W'({$urandom, $urandom});
					1: exp = sim_now - DL_W'($urandom_range(0, 20));
					default: exp = sim_now + DL_W'($urandom_range(0, 60));
				endcase
				per = '0;
				// periodic timers never leave, so keep them few
				if (book.periodic_count() < 8 && $urandom_range(0, 7) == 0)
					per = ($urandom_range(0, 15) == 0) ? PER_W'({$urandom, $urandom})
						: PER_W'($urandom_range(1, 100));
				send_beat(KIND_ADD, tag, exp, per, DL_W'({$urandom, $urandom}));
			end else begin
				sim_now = sim_now + DL_W'($urandom_range(0, 40));
				case ($urandom_range(0, 24))
					0: now = DL_MAX;
					1: now = DL_W'({$urandom, $urandom});
					2: now = sim_now - DL_W'($urandom_range(0, 100));
					default: now = sim_now;
				endcase
				send_beat(KIND_CHECK, TAG_W'($urandom_range(0, 255)),
					DL_W'({$urandom, $urandom}), PER_W'({$urandom, $urandom}), now);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (book.owed.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (book.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#(3_000_000);
		$display("FAILURE");
		$finish;
	end

endmodule
